>>> rtl/color_histogram_64bin_core_macros.svh
// Assertion macros used by the color histogram top-level file.
`ifndef COLOR_HISTOGRAM_64BIN_CORE_MACROS_SVH
`define COLOR_HISTOGRAM_64BIN_CORE_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define CH64_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CH64_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/ch64_pkg.sv
// Package with the types and constants of the color histogram block.
`default_nettype none

package ch64_pkg;

  // Number of histogram bins and the width of a bin number.
  localparam int unsigned NumBins  = 64;
  localparam int unsigned BinIdxW  = 6;
  // Width of the count field in a result item.
  localparam int unsigned OutCountW = 22;
  // Top two bits of a color channel byte.
  localparam logic [7:0]  ChanTopMask = 8'hC0;

  typedef logic [BinIdxW-1:0] bin_idx_t;

  localparam bin_idx_t LastBin = bin_idx_t'(NumBins - 1);

  // Memory read request.
  typedef struct packed {
    logic     en;
    bin_idx_t addr;
  } rd_req_t;

  // Request to clear one bin after it has been read out.
  typedef struct packed {
    logic     en;
    bin_idx_t addr;
  } clr_req_t;

  // Readout sequencer states.
  typedef enum logic [1:0] {
    RoIdle,
    RoIssue,
    RoLoad
  } ro_state_e;

endpackage

`default_nettype wire

>>> rtl/ch64_bin_mem.sv
// Bin counter memory with one write port, one registered read port and per-bin valid bits.
`default_nettype none

module ch64_bin_mem
  import ch64_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 22
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  we_i,
  input  wire bin_idx_t              waddr_i,
  input  wire logic [COUNT_BITS-1:0] wdata_i,
  input  wire rd_req_t               rd_i,
  input  wire clr_req_t              clr_i,
  output logic      [COUNT_BITS-1:0] rdata_o
);

  logic [COUNT_BITS-1:0] mem_q [NumBins];
  logic [NumBins-1:0]    valid_q;
  logic [COUNT_BITS-1:0] rdata_q;
  logic                  rvalid_q;

  // Counter storage; written by the update stage only.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read of the counter value.
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  // Valid bits: a bin that was never written since reset or readout reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (clr_i.en) begin
        valid_q[clr_i.addr] <= 1'b0;
      end
      if (rd_i.en) begin
        rvalid_q <= valid_q[rd_i.addr];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

>>> rtl/ch64_readout.sv
// Readout sequencer that streams all bins out of memory and clears them.
`default_nettype none

module ch64_readout
  import ch64_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 22
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  output rd_req_t                    rd_o,
  output clr_req_t                   clr_o,
  input  wire logic [COUNT_BITS-1:0] rdata_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output bin_idx_t                   out_idx_o,
  output logic      [OutCountW-1:0]  out_count_o,
  output logic                       out_last_o
);

  ro_state_e state_q, state_d;
  bin_idx_t  addr_q, addr_d;
  logic      out_vld_q;
  bin_idx_t  out_idx_q;
  logic [OutCountW-1:0] out_cnt_q;
  logic      out_last_q;
  logic      out_free;
  logic      load;
  logic [COUNT_BITS+OutCountW-1:0] cnt_ext;

  // The output register can take a new item when empty or being emptied.
  assign out_free = !out_vld_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      RoIdle: begin
        if (start_i) begin
          state_d = RoIssue;
        end
      end
      RoIssue: begin
        if (out_free) begin
          state_d = RoLoad;
        end
      end
      RoLoad: begin
        state_d = (addr_q == LastBin) ? RoIdle : RoIssue;
      end
      default: state_d = RoIdle;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    rd_o.en    = 1'b0;
    rd_o.addr  = addr_q;
    clr_o.en   = 1'b0;
    clr_o.addr = addr_q;
    load       = 1'b0;
    addr_d     = addr_q;
    busy_o     = 1'b1;
    case (state_q)
      RoIdle: begin
        busy_o = 1'b0;
      end
      RoIssue: begin
        rd_o.en = out_free;
      end
      RoLoad: begin
        clr_o.en = 1'b1;
        load     = 1'b1;
        addr_d   = addr_q + bin_idx_t'(1);
      end
      default: busy_o = 1'b0;
    endcase
  end

  // Counters wider than the count field are cut to its low bits.
  assign cnt_ext = {{OutCountW{1'b0}}, rdata_i};

  // Sequencer state and bin address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= RoIdle;
      addr_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_idx_q  <= addr_q;
      out_cnt_q  <= cnt_ext[OutCountW-1:0];
      out_last_q <= (addr_q == LastBin);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_idx_o   = out_idx_q;
  assign out_count_o = out_cnt_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

>>> rtl/color_histogram_64bin_core.sv
// Top level of the 64-bin quantized color histogram.
//
//  channel  dir  fields (low bit up)                       accepted when
//  s_axis   in   tdata: blue, green, red; tlast: frame end  tvalid && tready
//  m_axis   out  tdata: bin_index, bin_count; tlast: last   tvalid && tready
//
// An ordinary pixel is taken every cycle while no readout runs: its bin is
// read when it is accepted, then incremented and written back in the
// update stage, with the last write forwarded to a following pixel of the same bin.
// The frame-end pixel blocks input for the readout, which takes each bin through
// an issue and a load state on the single memory read port and holds in the issue
// state under output stalls. Reset clears all bins at once through their valid bits.
`default_nettype none

module color_histogram_64bin_core
  import ch64_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 22
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // blue[7:0], green[15:8], red[23:16]
  input  wire logic        s_axis_tlast,  // end_of_frame
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,  // bin_index[5:0], bin_count[27:6], zero fill
  output logic             m_axis_tlast   // last_bin
);

  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic      in_fire;
  bin_idx_t  in_idx;
  logic [7:0] blue_top, green_top, red_top;

  logic      s1_vld_q;
  bin_idx_t  s1_idx_q;
  logic      s1_eof_q;

  logic                  wr_vld_q;
  bin_idx_t              wr_idx_q;
  logic [COUNT_BITS-1:0] wr_cnt_q;

  logic [COUNT_BITS-1:0] mem_rdata;
  logic [COUNT_BITS-1:0] old_cnt;
  logic [COUNT_BITS-1:0] new_cnt;
  logic                  frame_end;

  rd_req_t  ro_rd, mem_rd;
  clr_req_t ro_clr;
  logic     ro_busy;
  bin_idx_t out_idx;
  logic [OutCountW-1:0] out_cnt;

  // Bin number from the top two bits of each channel, blue highest.
  assign blue_top  = s_axis_tdata[7:0]   & ChanTopMask;
  assign green_top = s_axis_tdata[15:8]  & ChanTopMask;
  assign red_top   = s_axis_tdata[23:16] & ChanTopMask;
  assign in_idx    = {blue_top[7:6], green_top[7:6], red_top[7:6]};

  // Input is held off while a frame end is being counted or read out.
  assign frame_end     = s1_vld_q && s1_eof_q;
  assign s_axis_tready = !ro_busy && !frame_end;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // The read port serves the pixel stage or the readout, never both.
  always_comb begin
    if (ro_busy) begin
      mem_rd = ro_rd;
    end else begin
      mem_rd.en   = in_fire;
      mem_rd.addr = in_idx;
    end
  end

  // Update stage: forward the previous write when it hit the same bin.
  assign old_cnt = (wr_vld_q && (wr_idx_q == s1_idx_q)) ? wr_cnt_q : mem_rdata;
  assign new_cnt = (old_cnt == CountMax) ? old_cnt : old_cnt + COUNT_BITS'(1);

  // Pipeline control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      wr_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_fire;
      wr_vld_q <= s1_vld_q;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_idx_q <= in_idx;
      s1_eof_q <= s_axis_tlast;
    end
    if (s1_vld_q) begin
      wr_idx_q <= s1_idx_q;
      wr_cnt_q <= new_cnt;
    end
  end

  ch64_bin_mem #(
    .COUNT_BITS (COUNT_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (s1_vld_q),
    .waddr_i (s1_idx_q),
    .wdata_i (new_cnt),
    .rd_i    (mem_rd),
    .clr_i   (ro_clr),
    .rdata_o (mem_rdata)
  );

  ch64_readout #(
    .COUNT_BITS (COUNT_BITS)
  ) u_readout (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (frame_end),
    .busy_o      (ro_busy),
    .rd_o        (ro_rd),
    .clr_o       (ro_clr),
    .rdata_i     (mem_rdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_idx_o   (out_idx),
    .out_count_o (out_cnt),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, out_cnt, out_idx};

  `include "color_histogram_64bin_core_macros.svh"

  // The final item of a readout carries the highest bin number.
  `CH64_ASSERT(a_last_is_top_bin, m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[5:0] == LastBin, "last item is not the top bin")
  // A pixel write never coincides with a readout access.
  `CH64_ASSERT(a_no_write_in_readout, s1_vld_q |-> !ro_rd.en && !ro_clr.en, "pixel write during readout")
  // A counted frame end always starts the readout.
  `CH64_ASSERT(a_frame_end_starts, frame_end |=> ro_busy, "readout did not start after frame end")
  // No result is offered right after reset.
  `CH64_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !m_axis_tvalid, "output valid right after reset")

endmodule

`default_nettype wire

>>> bench/ch64_histogram_checker.sv
// Checker that predicts the histogram readout and compares it with the result stream.
module ch64_histogram_checker
  import ch64_pkg::*;
#(
  parameter int unsigned CountBits = 22
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // One bin as it should leave the block during a readout.
  typedef struct packed {
    bin_idx_t               index;
    logic [OutCountW-1:0]   count;
    logic                   last;
  } bin_result_t;

  logic [CountBits-1:0] bin_tally [NumBins];
  bin_result_t          expected_bins_q [$];
  int                   fails = 0;

  // Bin number from the top two bits of each channel, blue most significant.
  function automatic bin_idx_t bin_of(logic [7:0] blue, logic [7:0] green, logic [7:0] red);
    return bin_idx_t'(((blue & ChanTopMask) >> 2) | ((green & ChanTopMask) >> 4)
                      | ((red & ChanTopMask) >> 6));
  endfunction

  // Count one pixel; a frame end queues the whole histogram and clears it.
  task automatic tally_pixel(input logic [23:0] pixel, input logic frame_end);
    bin_idx_t    idx;
    bin_result_t res;
    idx = bin_of(pixel[7:0], pixel[15:8], pixel[23:16]);
    if (bin_tally[idx] != '1) begin
      bin_tally[idx] = bin_tally[idx] + 1'b1;
    end
    if (frame_end) begin
      for (int k = 0; k < NumBins; k++) begin
        res.index = bin_idx_t'(k);
        res.count = OutCountW'(bin_tally[k]);
        res.last  = (res.index == LastBin);
        expected_bins_q.push_back(res);
        bin_tally[k] = '0;
      end
    end
  endtask

  // Compare one delivered bin with the oldest expected one.
  task automatic check_bin(input logic [31:0] data, input logic last);
    bin_result_t want;
    bin_idx_t    got_index;
    logic [OutCountW-1:0] got_count;
    got_index = data[BinIdxW-1:0];
    got_count = data[BinIdxW +: OutCountW];
    if (expected_bins_q.size() == 0) begin
      $error("unexpected result item: bin_index %0d, bin_count %0d", got_index, got_count);
      fails++;
    end else begin
      want = expected_bins_q.pop_front();
      if (got_index !== want.index) begin
        $error("bin_index mismatch: expected %0d, actual %0d", want.index, got_index);
        fails++;
      end
      if (got_count !== want.count) begin
        $error("bin_count mismatch: expected %0d, actual %0d", want.count, got_count);
        fails++;
      end
      if (last !== want.last) begin
        $error("last_bin mismatch: expected %0d, actual %0d", want.last, last);
        fails++;
      end
    end
  endtask

  // Results are checked before the pixel of the same edge is counted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumBins; k++) begin
        bin_tally[k] = '0;
      end
      expected_bins_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_bin(m_axis_tdata, m_axis_tlast);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        tally_pixel(s_axis_tdata, s_axis_tlast);
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_bins_q.size();
  end

endmodule

>>> bench/tb.sv
// Top of the color histogram testbench: clock, reset, pixel stimulus, result sink and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ch64_pkg::*;

  localparam int unsigned CountBits    = 22;
  localparam int          RandomPixels = 160;
  localparam int          IdleLimit    = 2000;
  localparam int          HoldOff      = 300;
  localparam int          PressureAt   = 200;
  localparam int          DrainCycles  = 140;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // blue[7:0], green[15:8], red[23:16]
  logic        s_axis_tlast;   // end_of_frame
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // bin_index[5:0], bin_count[27:6], zero fill
  logic        m_axis_tlast;   // last_bin
  int          fail_count;
  int          pending_bins;

  color_histogram_64bin_core #(
    .COUNT_BITS (CountBits)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  ch64_histogram_checker #(
    .CountBits (CountBits)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending_bins)
  );

  // Free-running 50 MHz clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Offer one pixel after an idle gap and hold it until it is accepted.
  task automatic send_pixel(input logic [7:0] blue, input logic [7:0] green,
                            input logic [7:0] red, input logic frame_end, input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {red, green, blue};
    s_axis_tlast  <= frame_end;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Pixel source: directed frames first, then random frames.
  initial begin
    int          sent;
    int          frame_len;
    bit          burst;
    logic [7:0]  b, g, r;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Single-pixel frames at both corners of the color cube.
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1, $urandom_range(0, 3));
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1, $urandom_range(0, 3));

    // Every top-bit pattern on each channel, then a run of one bin with the frame end in it.
    send_pixel(8'h40, 8'h00, 8'h00, 1'b0, $urandom_range(0, 3));
    send_pixel(8'h80, 8'h00, 8'h00, 1'b0, $urandom_range(0, 3));
    send_pixel(8'hC0, 8'h00, 8'h00, 1'b0, $urandom_range(0, 3));
    send_pixel(8'h00, 8'h40, 8'h00, 1'b0, $urandom_range(0, 3));
    send_pixel(8'h00, 8'h80, 8'h00, 1'b0, $urandom_range(0, 3));
    send_pixel(8'h00, 8'hC0, 8'h00, 1'b0, $urandom_range(0, 3));
    send_pixel(8'h00, 8'h00, 8'h40, 1'b0, $urandom_range(0, 3));
    send_pixel(8'h00, 8'h00, 8'h80, 1'b0, $urandom_range(0, 3));
    send_pixel(8'h00, 8'h00, 8'hC0, 1'b0, $urandom_range(0, 3));
    send_pixel(8'h3F, 8'h3F, 8'h3F, 1'b0, $urandom_range(0, 3));
    send_pixel(8'hC0, 8'hC0, 8'hC0, 1'b0, 0);
    send_pixel(8'hC0, 8'hC0, 8'hC0, 1'b0, 0);
    send_pixel(8'hFF, 8'hC1, 8'hDE, 1'b1, 0);

    // Two bins interleaved back to back.
    send_pixel(8'h12, 8'h55, 8'hA0, 1'b0, 0);
    send_pixel(8'hE0, 8'h30, 8'h7F, 1'b0, 0);
    send_pixel(8'h12, 8'h55, 8'hA0, 1'b0, 0);
    send_pixel(8'hE0, 8'h30, 8'h7F, 1'b1, 0);

    // Random frames, mostly short; about half the pixels repeat the previous bin.
    sent = 0;
    b = '0;
    g = '0;
    r = '0;
    while (sent < RandomPixels) begin
      frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      burst     = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < frame_len; i++) begin
        if (i > 0 && $urandom_range(0, 1) == 1) begin
          b = {b[7:6], 6'($urandom)};
          g = {g[7:6], 6'($urandom)};
          r = {r[7:6], 6'($urandom)};
        end else begin
          b = 8'($urandom);
          g = 8'($urandom);
          r = 8'($urandom);
        end
        send_pixel(b, g, r, (i == frame_len - 1), burst ? 0 : $urandom_range(0, 3));
      end
      sent += frame_len;
    end
    s_axis_tvalid <= 1'b0;

    // Wait for the last readout to drain, then give stray results a chance to show.
    do @(posedge clk_i); while (pending_bins != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Result sink with random stalls, calm stretches and one long hold-off.
  initial begin
    int received;
    int gap;
    bit calm;
    received = 0;
    calm     = 1'b0;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    forever begin
      if (received % NumBins == 0) begin
        calm = ($urandom_range(0, 3) == 0);
      end
      gap = calm ? 0 : $urandom_range(0, 3);
      if (received == PressureAt) begin
        gap = HoldOff;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      received++;
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("tb failed");
        $finish;
      end
    end
  end

endmodule
